/* design/bmp_stream_to_framebuffer_writer_core_assert.svh */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer writer: assertion macros
// Short forms for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_TO_FRAMEBUFFER_WRITER_CORE_ASSERT_SVH
`define BMP_STREAM_TO_FRAMEBUFFER_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BSFW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define BSFW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// What must hold in the cycle after a reset edge.
`define BSFW_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

/* design/bsfw_pkg.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer writer: package
// Shared types and constants of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsfw_pkg;

  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] ERR_MAGIC  = 3'd0;
  localparam logic [2:0] ERR_HEADER = 3'd1;
  localparam logic [2:0] ERR_BPP    = 3'd2;
  localparam logic [2:0] ERR_COMP   = 3'd3;
  localparam logic [2:0] ERR_OFFSET = 3'd4;
  localparam logic [2:0] ERR_ORIGIN = 3'd5;

  localparam logic [1:0] REG_FB_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FB_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X  = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y  = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  typedef struct packed {
    logic        is_error;
    logic [2:0]  code;
    logic [31:0] col;
    logic [31:0] row;
    logic [23:0] color;
  } rec_t;

endpackage

`default_nettype wire

/* design/bmp_stream_to_framebuffer_writer_core.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer writer core
// Decodes an uncompressed 24 or 32 bpp BMP byte stream into framebuffer
// pixel writes and header error reports.
// ----------------------------------------------------------------------------
// Usage:
//   File bytes enter through push/full, one per cycle while full is low; a byte
//   with first_byte high starts a new image. Results leave through
//   empty/pop: a pixel write (x, y, 0xRRGGBB) for every visible pixel, or
//   one error request when the header is rejected at file byte 53.
//   A result reaches the output ports through the request queue, the
//   clipping stage register and the result buffer. The parser handles one
//   byte every cycle while full is low; the sustained rate is one byte
//   per cycle as long as the receiver pops.
//   When the receiver stalls, the four-entry result buffer and the
//   four-entry request queue fill, and full rises once the queue is full.
//   Reset empties both queues, restores the framebuffer registers to
//   1024 x 768 at origin 0,0, and treats the next byte as file byte 0.
//   The user writes the framebuffer registers through cfg_write, cfg_index
//   and cfg_data only while no image is in flight; the core does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmp_stream_to_framebuffer_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        empty,
  input  logic        pop,
  output logic        is_error,
  output logic [2:0]  error_code,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [23:0] color,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]    fb_width;
  logic [15:0]    fb_height;
  logic [15:0]    origin_x;
  logic [15:0]    origin_y;
  logic           accept;
  logic           rec_valid;
  bsfw_pkg::rec_t rec;
  bsfw_pkg::rec_t q_head;
  logic           q_empty;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= 16'd1024;
      fb_height <= 16'd768;
      origin_x  <= 16'd0;
      origin_y  <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        bsfw_pkg::REG_FB_WIDTH:  fb_width  <= cfg_data;
        bsfw_pkg::REG_FB_HEIGHT: fb_height <= cfg_data;
        bsfw_pkg::REG_ORIGIN_X:  origin_x  <= cfg_data;
        bsfw_pkg::REG_ORIGIN_Y:  origin_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  bsfw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (accept),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .fb_width   (fb_width),
    .fb_height  (fb_height),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  bsfw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && rec_valid),
    .push_data (rec),
    .pop       (q_pop),
    .head      (q_head),
    .full      (full),
    .empty     (q_empty)
  );

  bsfw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .fb_width   (fb_width),
    .fb_height  (fb_height),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .pop        (pop),
    .empty      (empty),
    .is_error   (is_error),
    .error_code (error_code),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .color      (color)
  );

endmodule

`default_nettype wire

/* design/bsfw_front.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer writer: byte parser
// Parses the headers, skips to the pixel data, assembles pixels and tracks
// rows, and emits one request per finished pixel or rejected image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfw_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic [15:0]      fb_width,
  input  logic [15:0]      fb_height,
  input  logic [15:0]      origin_x,
  input  logic [15:0]      origin_y,
  output logic             rec_valid,
  output bsfw_pkg::rec_t   rec
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_PIXELS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  localparam logic [5:0]  POS_MAGIC  = 6'd1;
  localparam logic [5:0]  POS_OFFSET = 6'd13;
  localparam logic [5:0]  POS_INFO   = 6'd17;
  localparam logic [5:0]  POS_WIDTH  = 6'd21;
  localparam logic [5:0]  POS_HEIGHT = 6'd25;
  localparam logic [5:0]  POS_ABS    = 6'd26;
  localparam logic [5:0]  POS_PLANES = 6'd27;
  localparam logic [5:0]  POS_BPP    = 6'd29;
  localparam logic [5:0]  POS_COMP   = 6'd33;
  localparam logic [5:0]  POS_LAST   = 6'd53;
  localparam logic [15:0] MAGIC_BM   = 16'h4D42;
  localparam logic [31:0] MIN_INFO   = 32'd40;
  localparam logic [31:0] MIN_OFFSET = 32'd54;
  localparam logic [15:0] BPP_24     = 16'd24;
  localparam logic [15:0] BPP_32     = 16'd32;

  phase_t      phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [31:0] scratch, scratch_next;
  logic [31:0] offset, offset_next;
  logic [31:0] img_width, img_width_next;
  logic [31:0] img_height, img_height_next;
  logic        bpp4, bpp4_next;
  logic        err_valid, err_valid_next;
  logic [2:0]  err_code, err_code_next;
  logic [31:0] abs_h, abs_h_next;
  logic [31:0] disp_init, disp_init_next;
  logic [31:0] rows_left, rows_left_next;
  logic [31:0] disp, disp_next;
  logic [1:0]  bir, bir_next;
  logic [31:0] col, col_next;
  logic [23:0] asm_px, asm_px_next;

  phase_t      phase_c;
  logic [31:0] pos_c;
  logic [31:0] scr_c;
  logic        errv_c;
  logic [2:0]  errc_c;
  logic [1:0]  pad;

  assign phase_c = first_byte ? PH_HEADER : phase;
  assign pos_c   = first_byte ? 32'd0 : pos;
  assign scr_c   = first_byte ? 32'd0 : scratch;
  assign errv_c  = first_byte ? 1'b0 : err_valid;
  assign errc_c  = first_byte ? bsfw_pkg::CODE_NONE : err_code;
  assign pad     = bpp4 ? 2'd0 : img_width[1:0];

  always_comb begin
    logic [31:0] scr_new;
    logic        fail;
    logic [2:0]  fcode;
    logic        lfail4;
    logic        lfail5;
    logic [2:0]  bir3;
    logic        finish;
    logic [23:0] asm_b;

    phase_next      = phase_c;
    pos_next        = pos_c;
    scratch_next    = scr_c;
    offset_next     = offset;
    img_width_next  = img_width;
    img_height_next = img_height;
    bpp4_next       = bpp4;
    err_valid_next  = errv_c;
    err_code_next   = errc_c;
    abs_h_next      = abs_h;
    disp_init_next  = disp_init;
    rows_left_next  = rows_left;
    disp_next       = disp;
    bir_next        = bir;
    col_next        = col;
    asm_px_next     = asm_px;
    rec_valid       = 1'b0;
    rec             = '0;
    scr_new         = {data_byte, scr_c[31:8]};
    fail            = 1'b0;
    fcode           = bsfw_pkg::ERR_MAGIC;
    lfail4          = 1'b0;
    lfail5          = 1'b0;
    bir3            = {1'b0, bir} + 3'd1;
    finish          = 1'b0;
    asm_b           = asm_px;

    case (phase_c)
      PH_HEADER: begin
        scratch_next = scr_new;
        pos_next     = pos_c + 32'd1;
        case (pos_c[5:0])
          POS_MAGIC: begin
            fail  = scr_new[31:16] != MAGIC_BM;
            fcode = bsfw_pkg::ERR_MAGIC;
          end
          POS_OFFSET: offset_next = scr_new;
          POS_INFO: begin
            fail  = scr_new < MIN_INFO;
            fcode = bsfw_pkg::ERR_HEADER;
          end
          POS_WIDTH:  img_width_next = scr_new;
          POS_HEIGHT: img_height_next = scr_new;
          POS_ABS: begin
            abs_h_next     = img_height[31] ? (32'd0 - img_height) : img_height;
            disp_init_next = img_height - 32'd1;
          end
          POS_PLANES: begin
            fail  = scr_new[31:16] != 16'd1;
            fcode = bsfw_pkg::ERR_HEADER;
          end
          POS_BPP: begin
            if (scr_new[31:16] == BPP_24) begin
              bpp4_next = 1'b0;
            end else if (scr_new[31:16] == BPP_32) begin
              bpp4_next = 1'b1;
            end else begin
              fail  = 1'b1;
              fcode = bsfw_pkg::ERR_BPP;
            end
          end
          POS_COMP: begin
            fail  = scr_new != 32'd0;
            fcode = bsfw_pkg::ERR_COMP;
          end
          POS_LAST: begin
            lfail4      = offset < MIN_OFFSET;
            lfail5      = (origin_x >= fb_width) || (origin_y >= fb_height);
            col_next    = 32'd0;
            bir_next    = 2'd0;
            asm_px_next = 24'd0;
            rows_left_next = abs_h;
            disp_next   = img_height[31] ? 32'd0 : disp_init;
            if (errv_c || lfail4 || lfail5) begin
              rec_valid    = 1'b1;
              rec.is_error = 1'b1;
              rec.code     = errv_c ? errc_c :
                             (lfail4 ? bsfw_pkg::ERR_OFFSET : bsfw_pkg::ERR_ORIGIN);
              phase_next   = PH_DONE;
            end else if (img_width[31] || img_width == 32'd0 || abs_h == 32'd0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_PIXELS;
            end
          end
          default: ;
        endcase
        if (fail && !errv_c) begin
          err_valid_next = 1'b1;
          err_code_next  = fcode;
        end
      end
      PH_PIXELS: begin
        if (pos < offset) begin
          pos_next = pos + 32'd1;
        end else if (col >= img_width) begin
          if (bir3 >= {1'b0, pad}) begin
            finish = 1'b1;
          end else begin
            bir_next = bir3[1:0];
          end
        end else begin
          case (bir)
            2'd0:    asm_b[7:0]   = data_byte;
            2'd1:    asm_b[15:8]  = data_byte;
            2'd2:    asm_b[23:16] = data_byte;
            default: ;
          endcase
          if (bir3 < (bpp4 ? 3'd4 : 3'd3)) begin
            bir_next    = bir3[1:0];
            asm_px_next = asm_b;
          end else begin
            rec_valid   = 1'b1;
            rec.col     = col;
            rec.row     = disp;
            rec.color   = asm_b;
            asm_px_next = 24'd0;
            bir_next    = 2'd0;
            col_next    = col + 32'd1;
            if ((col + 32'd1 == img_width) && pad == 2'd0) begin
              finish = 1'b1;
            end
          end
        end
        if (finish) begin
          col_next       = 32'd0;
          bir_next       = 2'd0;
          rows_left_next = rows_left - 32'd1;
          disp_next      = img_height[31] ? (disp + 32'd1) : (disp - 32'd1);
          if (rows_left == 32'd1) begin
            phase_next = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      pos        <= 32'd0;
      scratch    <= 32'd0;
      offset     <= 32'd0;
      img_width  <= 32'd0;
      img_height <= 32'd0;
      bpp4       <= 1'b0;
      err_valid  <= 1'b0;
      err_code   <= bsfw_pkg::CODE_NONE;
      abs_h      <= 32'd0;
      disp_init  <= 32'd0;
      rows_left  <= 32'd0;
      disp       <= 32'd0;
      bir        <= 2'd0;
      col        <= 32'd0;
      asm_px     <= 24'd0;
    end else if (byte_valid) begin
      phase      <= phase_next;
      pos        <= pos_next;
      scratch    <= scratch_next;
      offset     <= offset_next;
      img_width  <= img_width_next;
      img_height <= img_height_next;
      bpp4       <= bpp4_next;
      err_valid  <= err_valid_next;
      err_code   <= err_code_next;
      abs_h      <= abs_h_next;
      disp_init  <= disp_init_next;
      rows_left  <= rows_left_next;
      disp       <= disp_next;
      bir        <= bir_next;
      col        <= col_next;
      asm_px     <= asm_px_next;
    end
  end

endmodule

`default_nettype wire

/* design/bsfw_queue.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer writer: request queue
// Small queue that decouples the byte parser from the clipping stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsfw_pkg::rec_t push_data,
  input  logic           pop,
  output bsfw_pkg::rec_t head,
  output logic           full,
  output logic           empty
);

  bsfw_pkg::rec_t                 mem [bsfw_pkg::QUEUE_DEPTH];
  logic [bsfw_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [bsfw_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [bsfw_pkg::QPTR_BITS:0]   count;

  assign full  = count == (bsfw_pkg::QPTR_BITS + 1)'(bsfw_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/bsfw_back.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer writer: clipping and result buffer
// Places each pixel at the origin, drops what falls off the framebuffer and
// buffers the results for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  bsfw_pkg::rec_t q_head,
  output logic           q_pop,
  input  logic [15:0]    fb_width,
  input  logic [15:0]    fb_height,
  input  logic [15:0]    origin_x,
  input  logic [15:0]    origin_y,
  input  logic           pop,
  output logic           empty,
  output logic           is_error,
  output logic [2:0]     error_code,
  output logic [15:0]    pixel_x,
  output logic [15:0]    pixel_y,
  output logic [23:0]    color
);

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_BITS = 2;

  typedef struct packed {
    logic        is_error;
    logic [2:0]  code;
    logic [15:0] x;
    logic [15:0] y;
    logic [23:0] color;
  } out_t;

  logic          s1_valid;
  logic          s1_err;
  logic [2:0]    s1_code;
  logic [32:0]   s1_px;
  logic [32:0]   s1_py;
  logic [23:0]   s1_color;
  logic          visible;
  logic          opush;
  logic          opop;
  out_t          oentry;
  out_t          omem [OUT_DEPTH];
  logic [OPTR_BITS-1:0] owr;
  logic [OPTR_BITS-1:0] ord;
  logic [OPTR_BITS:0]   ocount;

  assign q_pop = !q_empty &&
                 (({1'b0, ocount} + {{(OPTR_BITS + 1){1'b0}}, s1_valid})
                  < (OPTR_BITS + 2)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_err   <= q_head.is_error;
      s1_code  <= q_head.code;
      s1_px    <= {17'd0, origin_x} + {1'b0, q_head.col};
      s1_py    <= {17'd0, origin_y} + {1'b0, q_head.row};
      s1_color <= q_head.color;
    end
  end

  assign visible = s1_err ||
                   ((s1_px < {17'd0, fb_width}) && (s1_py < {17'd0, fb_height}));
  assign opush   = s1_valid && visible;
  assign opop    = pop && !empty;

  always_comb begin
    oentry.is_error = s1_err;
    oentry.code     = s1_err ? s1_code : bsfw_pkg::CODE_NONE;
    oentry.x        = s1_err ? 16'd0 : s1_px[15:0];
    oentry.y        = s1_err ? 16'd0 : s1_py[15:0];
    oentry.color    = s1_err ? 24'd0 : s1_color;
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      omem[owr] <= oentry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= '0;
      ord    <= '0;
      ocount <= '0;
    end else begin
      if (opush) begin
        owr <= owr + 1'b1;
      end
      if (opop) begin
        ord <= ord + 1'b1;
      end
      if (opush && !opop) begin
        ocount <= ocount + 1'b1;
      end else if (opop && !opush) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

  assign empty      = ocount == '0;
  assign is_error   = omem[ord].is_error;
  assign error_code = omem[ord].code;
  assign pixel_x    = omem[ord].x;
  assign pixel_y    = omem[ord].y;
  assign color      = omem[ord].color;

endmodule

`default_nettype wire

/* design/bsfw_checker.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer writer: port checker
// Concurrent checks on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bmp_stream_to_framebuffer_writer_core_assert.svh"

module bsfw_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        is_error,
  input logic [2:0]  error_code,
  input logic [15:0] pixel_x,
  input logic [15:0] pixel_y,
  input logic [23:0] color
);

  `BSFW_ASSERT_RST(a_reset_clears, empty && !full, "queues not empty after reset")
  `BSFW_ASSERT_NXT(a_result_held, !empty && !pop, !empty, "waiting result was lost")
  `BSFW_ASSERT_NXT(a_result_stable, !empty && !pop, $stable(pixel_x) && $stable(pixel_y) && $stable(color) && $stable(is_error), "waiting result changed")
  `BSFW_ASSERT_IMP(a_error_fields, !empty && is_error, (pixel_x == 16'd0) && (pixel_y == 16'd0) && (color == 24'd0) && (error_code <= bsfw_pkg::ERR_ORIGIN), "malformed error result")
  `BSFW_ASSERT_IMP(a_pixel_code, !empty && !is_error, error_code == bsfw_pkg::CODE_NONE, "pixel write carries an error code")

endmodule

bind bmp_stream_to_framebuffer_writer_core bsfw_checker u_bsfw_checker (.*);

`default_nettype wire
